// ===== rtl/core/msr_pkg.sv =====
// Shared types, constants and symbol decode for the Manchester frame receiver.
package msr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HALF_W = 9;
    localparam int unsigned NIB_W  = 4;

    localparam logic [BYTE_W-1:0] FRAME_PAIRS_RESET = 8'd141;
    localparam logic [1:0]        SYM_ONE           = 2'b01;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              last;
    } result_t;

    // Four symbols, MSB first; only 01 decodes to a one.
    function automatic logic [NIB_W-1:0] symbols_to_nibble(input logic [BYTE_W-1:0] b);
        logic [NIB_W-1:0] n;
        n[3] = (b[7:6] == SYM_ONE);
        n[2] = (b[5:4] == SYM_ONE);
        n[1] = (b[3:2] == SYM_ONE);
        n[0] = (b[1:0] == SYM_ONE);
        return n;
    endfunction

endpackage

// ===== rtl/core/msr_decode.sv =====
// Input register, frame position state and pair decode.
module msr_decode (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [msr_pkg::BYTE_W-1:0]  s_rx_byte,
    input  logic [msr_pkg::BYTE_W-1:0]  frame_pairs,
    input  logic                        room,
    output logic                        push,
    output msr_pkg::result_t            push_word
);
    import msr_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               prev_zero_reg, prev_zero_next;
    logic [HALF_W-1:0]  half_pos_reg, half_pos_next;
    logic [NIB_W-1:0]   high_nib_reg, high_nib_next;

    logic               advance;
    logic               byte_zero;
    logic [NIB_W-1:0]   nib;
    logic [BYTE_W-1:0]  pair;
    logic               is_last;
    logic [HALF_W-1:0]  half_inc;

    assign advance   = in_valid_reg && room;
    assign s_ready   = !in_valid_reg || room;
    assign byte_zero = (in_byte_reg == '0);
    assign nib       = symbols_to_nibble(in_byte_reg);
    assign pair      = half_pos_reg[HALF_W-1:1];
    assign half_inc  = half_pos_reg + HALF_W'(1);
    assign is_last   = ({1'b0, pair} + HALF_W'(1)) >= {1'b0, frame_pairs};

    assign push_word.data_byte  = {high_nib_reg, nib};
    assign push_word.byte_index = pair;
    assign push_word.last       = is_last;

    always_comb begin
        in_valid_next  = in_valid_reg;
        prev_zero_next = prev_zero_reg;
        half_pos_next  = half_pos_reg;
        high_nib_next  = high_nib_reg;
        push           = 1'b0;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            if (byte_zero) begin
                // second zero in a row resyncs the frame
                if (prev_zero_reg) begin
                    half_pos_next = '0;
                end
                prev_zero_next = 1'b1;
            end else begin
                prev_zero_next = 1'b0;
                if (!half_pos_reg[0]) begin
                    high_nib_next = nib;
                    half_pos_next = half_inc;
                end else begin
                    push          = 1'b1;
                    half_pos_next = is_last ? '0 : half_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            prev_zero_reg <= 1'b1;
            half_pos_reg  <= '0;
            high_nib_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            prev_zero_reg <= prev_zero_next;
            half_pos_reg  <= half_pos_next;
            high_nib_reg  <= high_nib_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

endmodule

// ===== rtl/core/msr_obuf.sv =====
// Two-entry result buffer between decode and the output channel.
module msr_obuf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  msr_pkg::result_t      push_word,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output msr_pkg::result_t      m_word
);
    import msr_pkg::*;

    result_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign room    = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_word  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/core/manchester_frame_receiver_top.sv =====
// Manchester frame receiver: decodes line byte pairs into indexed frame bytes.
//
//  channel  | direction | signals
//  ---------+-----------+----------------------------------------------
//  s_       | in        | s_valid, s_ready, s_rx_byte
//  m_       | out       | m_valid, m_ready, m_data_byte, m_byte_index, m_last
//  cfg_     | in        | cfg_valid, cfg_ready, cfg_frame_pairs
//
// One line byte per cycle while the result buffer has room.
// The input register feeds the decode and position counter, results go to a
// two-entry buffer, so a stalled output side still lets words in until both entries are full.
// Synchronous active-low reset; frame length resets to 141 and cfg_ready is always high.
module manchester_frame_receiver_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [msr_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [msr_pkg::BYTE_W-1:0]  m_data_byte,
    output logic [msr_pkg::BYTE_W-1:0]  m_byte_index,
    output logic                        m_last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [msr_pkg::BYTE_W-1:0]  cfg_frame_pairs
);
    import msr_pkg::*;

    logic [BYTE_W-1:0] frame_pairs_reg;
    logic              room;
    logic              push;
    result_t           push_word;
    result_t           m_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pairs_reg <= FRAME_PAIRS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frame_pairs_reg <= cfg_frame_pairs;
        end
    end

    msr_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .frame_pairs (frame_pairs_reg),
        .room        (room),
        .push        (push),
        .push_word   (push_word)
    );

    msr_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    assign m_data_byte  = m_word.data_byte;
    assign m_byte_index = m_word.byte_index;
    assign m_last       = m_word.last;

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("result pushed into full buffer");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid)
        else $error("pushed result not presented");

    a_top_index_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_index == 8'hFF) |-> m_last)
        else $error("byte at top index not marked last");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (!room && !s_ready && s_valid) |=> $stable(m_word) || $past(m_valid && m_ready))
        else $error("buffer contents changed while full and not drained");

endmodule
